// ----- rtl/pbd_pkg.sv -----
package pbd_pkg;

    localparam int CfgIdxW      = 3;
    localparam int FilterSections = 2;
    localparam int SampleBits   = 12;

    localparam logic [CfgIdxW-1:0] REG_REFRACTORY = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_IVL_MIN    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_IVL_MAX    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ATTACK     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DECAY      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_THR_RATIO  = 3'd5;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_UPSTROKE = 2'd1;
    localparam logic [1:0] EV_SLOPEMAX = 2'd2;
    localparam logic [1:0] EV_PEAK     = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_RISING   = 2'd1,
        PH_SLOPEMAX = 2'd2
    } t_phase;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_SEC_Y,
        S_SEC_D0,
        S_SEC_D1,
        S_SEC_NEXT,
        S_ENV,
        S_THR,
        S_DETECT,
        S_DIVIDE,
        S_COMMIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic do_scale;
        logic do_y;
        logic do_d0;
        logic do_d1;
        logic next_sec;
        logic do_env;
        logic do_thr;
        logic do_detect;
        logic div_step;
        logic do_commit;
    } t_cmd;

    typedef struct packed {
        logic last_sec;
        logic need_div;
    } t_status;

    // biquad coefficients, Q22: b0 b1 b2 a1 a2
    function automatic logic signed [23:0] coef(input int sec, input int idx);
        logic signed [23:0] c;
        c = 24'sd0;
        case (sec)
            0: case (idx)
                0: c = 24'sd4168111;
                1: c = -24'sd8336222;
                2: c = 24'sd4168111;
                3: c = 24'sd8335979;
                default: c = -24'sd4142160;
            endcase
            1: case (idx)
                0: c = 24'sd282928;
                1: c = 24'sd565856;
                2: c = 24'sd282928;
                3: c = 24'sd4794008;
                default: c = -24'sd1731415;
            endcase
            default: c = (idx == 0) ? 24'sd4194304 : 24'sd0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/pbd_ctrl.sv -----
module pbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_fire,
    input  logic             i_out_free,
    input  pbd_pkg::t_status i_status,
    output pbd_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_load
);
    import pbd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_fire) n_state = S_SCALE;
            S_SCALE:    n_state = S_SEC_Y;
            S_SEC_Y:    n_state = S_SEC_D0;
            S_SEC_D0:   n_state = S_SEC_D1;
            S_SEC_D1:   n_state = i_status.last_sec ? S_ENV : S_SEC_NEXT;
            S_SEC_NEXT: n_state = S_SEC_Y;
            S_ENV:      n_state = S_THR;
            S_THR:      n_state = S_DETECT;
            S_DETECT:   n_state = i_status.need_div ? S_DIVIDE : S_COMMIT;
            S_DIVIDE:   n_state = S_COMMIT;
            S_COMMIT:   n_state = S_OUT;
            S_OUT:      if (i_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.start = i_in_fire;
            end
            S_SCALE:    o_cmd.do_scale = 1'b1;
            S_SEC_Y:    o_cmd.do_y = 1'b1;
            S_SEC_D0:   o_cmd.do_d0 = 1'b1;
            S_SEC_D1:   o_cmd.do_d1 = 1'b1;
            S_SEC_NEXT: o_cmd.next_sec = 1'b1;
            S_ENV:      o_cmd.do_env = 1'b1;
            S_THR:      o_cmd.do_thr = 1'b1;
            S_DETECT:   o_cmd.do_detect = 1'b1;
            S_DIVIDE:   o_cmd.div_step = 1'b1;
            S_COMMIT:   o_cmd.do_commit = 1'b1;
            S_OUT:      o_out_load = i_out_free;
            default:    o_cmd = '0;
        endcase
    end
endmodule

// ----- rtl/pbd_datapath.sv -----
module pbd_datapath #(
    parameter int FILTER_SECTIONS = pbd_pkg::FilterSections,
    parameter int SAMPLE_BITS     = pbd_pkg::SampleBits
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbd_pkg::t_cmd                 i_cmd,
    output pbd_pkg::t_status              o_status,
    input  logic [SAMPLE_BITS-1:0]        i_adc_sample,
    input  logic [31:0]                   i_time_us,
    input  logic                          i_cfg_we,
    input  logic [pbd_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    output logic signed [27:0]            o_filtered_value,
    output logic [1:0]                    o_beat_event,
    output logic [15:0]                   o_interval_ms,
    output logic                          o_interval_fresh
);
    import pbd_pkg::*;

    localparam int SecW = (FILTER_SECTIONS > 1) ? $clog2(FILTER_SECTIONS) : 1;
    localparam int DlyW = (FILTER_SECTIONS > 1) ? $clog2(2*FILTER_SECTIONS) : 1;

    // volts scaling: adc*33*2^20 = adc*33*(q0*div + r0), so only the r0 part
    // needs a divide, done by reciprocal multiplication
    localparam longint unsigned FullL   = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam longint unsigned ScDiv   = 64'd10 * FullL;
    localparam longint unsigned ScQ0    = (64'd1 << 20) / ScDiv;
    localparam longint unsigned ScR0    = (64'd1 << 20) % ScDiv;
    localparam longint unsigned ScN2Max = 64'd33 * FullL * ScR0 + 64'd5 * FullL;
    localparam int ScAW    = SAMPLE_BITS + 6;
    localparam int ScNW    = $clog2(ScN2Max + 64'd1);
    localparam int ScShift = ScNW + $clog2(ScDiv);
    localparam longint unsigned ScRecip = ((64'd1 << ScShift) + ScDiv - 64'd1) / ScDiv;
    localparam int ScMW    = $clog2(ScRecip + 64'd1);
    localparam int ScPW    = ScNW + ScMW;

    // exact floor of a 32-bit value over 1000: multiply, then drop 38 bits
    localparam logic [28:0] MsRecip = 29'd274877907;

    // configuration
    logic [23:0] r_refr;
    logic [15:0] r_imin, r_imax, r_att, r_dec, r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refr  <= 24'd300000;
            r_imin  <= 16'd250;
            r_imax  <= 16'd2000;
            r_att   <= 16'd26214;
            r_dec   <= 16'd1311;
            r_ratio <= 16'd9830;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REFRACTORY: r_refr  <= i_cfg_data[23:0];
                REG_IVL_MIN:    r_imin  <= i_cfg_data[15:0];
                REG_IVL_MAX:    r_imax  <= i_cfg_data[15:0];
                REG_ATTACK:     r_att   <= i_cfg_data[15:0];
                REG_DECAY:      r_dec   <= i_cfg_data[15:0];
                REG_THR_RATIO:  r_ratio <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // item registers
    logic [ScNW-1:0]        r_sc_n2;
    logic [31:0]            r_sc_base;
    logic [31:0]            r_now;
    logic signed [31:0]     r_x;      // section input
    logic signed [27:0]     r_y;      // section output
    logic [SecW-1:0]        r_sec;
    logic signed [31:0]     r_dly [2*FILTER_SECTIONS];
    logic [31:0]            r_env;
    logic signed [31:0]     r_thr;
    logic signed [31:0]     r_pv, r_ps, r_pc;
    t_phase                 r_phase;
    logic [31:0]            r_last_pk;
    logic                   r_have_pk;
    logic [15:0]            r_good;
    logic                   r_seen;
    logic [1:0]             r_event;
    logic                   r_peak_hit;
    logic [31:0]            r_elapsed;
    t_phase                 r_phase_new;

    logic [DlyW-1:0] d_even, d_odd;
    assign d_even = DlyW'({r_sec, 1'b0});
    assign d_odd  = DlyW'({r_sec, 1'b1});

    // shared mac: two products of coefficient by signal plus a delay term, summed, rounded to q20
    logic signed [23:0] m_c0, m_c1;
    logic signed [31:0] m_a0, m_a1;
    logic signed [31:0] m_add;
    logic signed [57:0] m_sum;
    logic signed [35:0] m_q20;
    logic signed [31:0] m_sat32;
    logic signed [27:0] m_sat28;

    always_comb begin
        m_c0 = coef(int'(r_sec), 0);
        m_c1 = 24'sd0;
        m_a0 = r_x;
        m_a1 = 32'sd0;
        m_add = r_dly[d_even];
        if (i_cmd.do_d0) begin
            m_c0 = coef(int'(r_sec), 1);
            m_c1 = coef(int'(r_sec), 3);
            m_a1 = 32'(r_y);
            m_add = r_dly[d_odd];
        end else if (i_cmd.do_d1) begin
            m_c0 = coef(int'(r_sec), 2);
            m_c1 = coef(int'(r_sec), 4);
            m_a1 = 32'(r_y);
            m_add = 32'sd0;
        end
        m_sum = 58'(m_c0 * m_a0) + 58'(m_c1 * m_a1) + (58'(m_add) <<< 22)
              + 58'sd2097152;
        m_q20 = 36'(m_sum >>> 22);
        if (m_q20 > 36'sd2147483647) m_sat32 = 32'sh7fffffff;
        else if (m_q20 < -36'sd2147483648) m_sat32 = 32'sh80000000;
        else m_sat32 = m_q20[31:0];
        if (m_q20 > 36'sd134217727) m_sat28 = 28'sh7ffffff;
        else if (m_q20 < -36'sd134217728) m_sat28 = 28'sh8000000;
        else m_sat28 = m_q20[27:0];
    end

    // volts scaling datapath
    logic [ScAW-1:0] sc_a;
    logic [ScNW-1:0] sc_n2;
    logic [31:0]     sc_base;
    logic [ScPW-1:0] sc_prod;
    assign sc_a    = ScAW'(i_adc_sample) * ScAW'(33);
    assign sc_n2   = ScNW'(sc_a) * ScNW'(ScR0) + ScNW'(64'd5 * FullL);
    assign sc_base = 32'(sc_a) * 32'(ScQ0);
    assign sc_prod = ScPW'(r_sc_n2) * ScPW'(ScRecip);

    // envelope
    logic [31:0] y_mag;
    logic [15:0] env_g;
    logic [49:0] env_sum;
    logic [48:0] thr_prod;
    assign y_mag = r_y[27] ? 32'(-33'(r_y)) : 32'(r_y);
    assign env_g = (y_mag > r_env) ? r_att : r_dec;
    assign env_sum = 50'(env_g) * 50'(y_mag) + (50'(17'h10000 - 17'(env_g)) * 50'(r_env))
                   + 50'd32768;
    assign thr_prod = 49'(r_ratio) * 49'(r_env) + 49'd32768;

    // detector
    logic signed [31:0] y32, slope, curv;
    logic [31:0] elapsed;
    t_phase ph;
    logic [1:0] ev;
    logic peak;
    always_comb begin
        y32 = 32'(r_y);
        slope = y32 - r_pv;
        curv = slope - r_ps;
        elapsed = r_now - r_last_pk;
        ph = r_phase;
        ev = EV_NONE;
        peak = 1'b0;
        if (ph == PH_IDLE && y32 < r_thr && y32 >= r_pv && r_ps < 0 && slope >= 0) begin
            ev = EV_UPSTROKE;
            ph = PH_RISING;
        end
        if (ph == PH_RISING && y32 > r_thr && slope > 0 && r_pc > 0 && curv <= 0) begin
            ev = EV_SLOPEMAX;
            ph = PH_SLOPEMAX;
        end
        if (ph == PH_SLOPEMAX && y32 > r_thr && r_ps > 0 && slope <= 0 &&
            (!r_have_pk || elapsed > 32'(r_refr))) begin
            ev = EV_PEAK;
            ph = PH_IDLE;
            peak = 1'b1;
        end
    end

    // divide by 1000 in one step
    logic [31:0] r_dq;
    logic [60:0] ms_prod;
    assign ms_prod = 61'(r_elapsed) * 61'(MsRecip);

    assign o_status.last_sec = (int'(r_sec) == FILTER_SECTIONS - 1);
    assign o_status.need_div = peak && r_have_pk;

    logic [31:0] ms;
    assign ms = r_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2*FILTER_SECTIONS; k++) r_dly[k] <= 32'sd0;
            r_env <= 32'd0;
            r_pv <= 32'sd0;
            r_ps <= 32'sd0;
            r_pc <= 32'sd0;
            r_phase <= PH_IDLE;
            r_last_pk <= 32'd0;
            r_have_pk <= 1'b0;
            r_good <= 16'd0;
            r_seen <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_sc_n2 <= sc_n2;
                r_sc_base <= sc_base;
                r_now <= i_time_us;
                r_sec <= '0;
            end
            if (i_cmd.do_scale) r_x <= $signed(r_sc_base + 32'(sc_prod[ScPW-1:ScShift]));
            if (i_cmd.do_y) r_y <= m_sat28;
            if (i_cmd.do_d0) r_dly[d_even] <= m_sat32;
            if (i_cmd.do_d1) r_dly[d_odd] <= m_sat32;
            if (i_cmd.next_sec) begin
                r_sec <= r_sec + 1'b1;
                r_x <= 32'(r_y);
            end
            if (i_cmd.do_env) r_env <= env_sum[47:16];
            if (i_cmd.do_thr) r_thr <= 32'(thr_prod[47:16]);
            if (i_cmd.do_detect) begin
                r_event <= ev;
                r_peak_hit <= peak;
                r_phase_new <= ph;
                r_elapsed <= elapsed;
                r_pc <= curv;
                r_ps <= slope;
                r_pv <= y32;
            end
            if (i_cmd.div_step) r_dq <= {9'd0, ms_prod[60:38]};
            if (i_cmd.do_commit) begin
                r_phase <= r_phase_new;
                o_interval_fresh <= 1'b0;
                o_interval_ms <= 16'd0;
                o_beat_event <= r_event;
                o_filtered_value <= r_y;
                if (r_peak_hit) begin
                    r_last_pk <= r_now;
                    r_have_pk <= 1'b1;
                    if (r_have_pk && ms >= 32'(r_imin) && ms <= 32'(r_imax)) begin
                        r_good <= ms[15:0];
                        r_seen <= 1'b1;
                        o_interval_fresh <= 1'b1;
                        o_interval_ms <= ms[15:0];
                    end else begin
                        o_interval_ms <= r_seen ? r_good : 16'd0;
                    end
                end
            end
        end
    end
endmodule

// ----- rtl/ppg_beat_detector_top.sv -----
// ppg beat detector: one 12-bit sample plus microsecond timestamp in, one result out
// (filtered value, event, interval). Each item goes through scaling, the filter sections
// in turn on the single shared multiply-accumulate, envelope, threshold and detection,
// a divide-by-1000 on a peak that follows an earlier peak, and commit; the next
// item is taken once the result has moved into the output register.
module ppg_beat_detector_top #(
    parameter int FILTER_SECTIONS = pbd_pkg::FilterSections,
    parameter int SAMPLE_BITS     = pbd_pkg::SampleBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // adc_sample[11:0], time_us[43:12], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // filtered_value, beat_event, interval_ms, fresh
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pbd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import pbd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_fire, out_load;
    logic    r_ovalid;
    logic signed [27:0] fv;
    logic [1:0]  evt;
    logic [15:0] ivl;
    logic        fresh;
    logic [47:0] r_odata;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    pbd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_out_free(!r_ovalid || m_axis_tready), .i_status(status), .o_cmd(cmd),
        .o_in_ready(s_axis_tready), .o_out_load(out_load)
    );

    pbd_datapath #(.FILTER_SECTIONS(FILTER_SECTIONS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_adc_sample(SAMPLE_BITS'(s_axis_tdata[11:0])), .i_time_us(s_axis_tdata[43:12]),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_filtered_value(fv), .o_beat_event(evt), .o_interval_ms(ivl),
        .o_interval_fresh(fresh)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_odata <= {1'b0, fresh, ivl, evt, fv};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

// ----- sim/ppg_beat_detector_checker.sv -----
module ppg_beat_detector_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [47:0]                 m_axis_tdata,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [pbd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output int                          o_pending,
    output int                          o_fails
);
    timeunit 1ns;
    timeprecision 1ps;
    import pbd_pkg::*;

    // packed from the top bit down: fresh, interval, event, value
    typedef struct packed {
        logic               fresh;
        logic [15:0]        ivl;
        logic [1:0]         beat;
        logic signed [27:0] value;
    } t_beat_result;

    t_beat_result expected_beats[$];

    // Q22 biquad taps: b0 b1 b2 a1 a2, high-pass then low-pass
    longint taps [2][5] = '{
        '{64'sd4168111, -64'sd8336222, 64'sd4168111, 64'sd8335979, -64'sd4142160},
        '{64'sd282928, 64'sd565856, 64'sd282928, 64'sd4794008, -64'sd1731415}
    };

    logic [23:0] refr_gap_us;
    logic [15:0] ivl_min, ivl_max, attack_gain, decay_gain, thr_ratio;

    longint      delay_line [4];
    logic [31:0] envelope;
    int          last_value, last_slope, last_curv;
    t_phase      phase;
    logic [31:0] last_peak_us;
    logic        have_peak, ivl_valid;
    logic [15:0] good_ivl;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_q20(longint v);
        longint c;
        c = clamp(v, -(64'sd1 <<< 61), 64'sd1 <<< 61);
        return (c + (64'sd1 <<< 21)) >>> 22;
    endfunction

    function automatic void reset_model();
        refr_gap_us = 24'd300000;
        ivl_min = 16'd250;
        ivl_max = 16'd2000;
        attack_gain = 16'd26214;
        decay_gain = 16'd1311;
        thr_ratio = 16'd9830;
        foreach (delay_line[k]) delay_line[k] = 0;
        envelope = '0;
        last_value = 0;
        last_slope = 0;
        last_curv = 0;
        phase = PH_IDLE;
        last_peak_us = '0;
        have_peak = 1'b0;
        good_ivl = '0;
        ivl_valid = 1'b0;
    endfunction

    function automatic t_beat_result detect_beat(logic [11:0] adc, logic [31:0] now);
        t_beat_result r;
        longint      x, y, mag;
        longint unsigned gain, env_next, thr_u;
        int          yi, slope, curv, thr;
        logic [31:0] elapsed, ms;
        r = '0;
        x = longint'((64'd33 * adc * (64'd1 << 20) + 64'd5 * 4095) / 64'd40950);
        for (int k = 0; k < 2; k++) begin
            y = clamp(round_q20(taps[k][0] * x + delay_line[2*k] * 4194304),
                      -(64'sd1 <<< 27), (64'sd1 <<< 27) - 1);
            delay_line[2*k] = clamp(round_q20(taps[k][1] * x + taps[k][3] * y
                                              + delay_line[2*k+1] * 4194304),
                                    -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
            delay_line[2*k+1] = clamp(round_q20(taps[k][2] * x + taps[k][4] * y),
                                      -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
            x = y;
        end
        yi = int'(x);
        mag = x < 0 ? -x : x;
        gain = (longint'(mag) > longint'({32'd0, envelope})) ? attack_gain : decay_gain;
        env_next = (gain * longint'(mag) + (64'd65536 - gain) * envelope + 64'd32768) >> 16;
        envelope = env_next[31:0];
        thr_u = (longint'(thr_ratio) * envelope + 64'd32768) >> 16;
        thr = int'(thr_u[31:0]);
        slope = yi - last_value;
        curv = slope - last_slope;

        if (phase == PH_IDLE) begin
            if (yi < thr && yi >= last_value && last_slope < 0 && slope >= 0) begin
                r.beat = EV_UPSTROKE;
                phase = PH_RISING;
            end
        end
        // a phase entered above is tested again in the same sample
        if (phase == PH_RISING) begin
            if (yi > thr && slope > 0 && last_curv > 0 && curv <= 0) begin
                r.beat = EV_SLOPEMAX;
                phase = PH_SLOPEMAX;
            end
        end
        if (phase == PH_SLOPEMAX) begin
            elapsed = now - last_peak_us;
            if (yi > thr && last_slope > 0 && slope <= 0 &&
                (!have_peak || elapsed > {8'd0, refr_gap_us})) begin
                if (have_peak) begin
                    ms = elapsed / 1000;
                    if (ms >= ivl_min && ms <= ivl_max) begin
                        good_ivl = ms[15:0];
                        ivl_valid = 1'b1;
                        r.fresh = 1'b1;
                    end
                end
                last_peak_us = now;
                have_peak = 1'b1;
                r.beat = EV_PEAK;
                r.ivl = ivl_valid ? good_ivl : 16'd0;
                phase = PH_IDLE;
            end
        end
        last_curv = curv;
        last_slope = slope;
        last_value = yi;
        r.value = x[27:0];
        return r;
    endfunction

    assign o_pending = expected_beats.size();

    always @(posedge i_clk) begin
        t_beat_result got, want;
        if (!i_rst_n) begin
            reset_model();
            expected_beats.delete();
            o_fails <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_REFRACTORY: refr_gap_us = i_cfg_data[23:0];
                    REG_IVL_MIN:    ivl_min = i_cfg_data[15:0];
                    REG_IVL_MAX:    ivl_max = i_cfg_data[15:0];
                    REG_ATTACK:     attack_gain = i_cfg_data[15:0];
                    REG_DECAY:      decay_gain = i_cfg_data[15:0];
                    REG_THR_RATIO:  thr_ratio = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[46:0];
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fails <= o_fails + 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want || m_axis_tdata[47] !== 1'b0) begin
                        $display("%0t: mismatch expected value=%0d event=%0d ivl=%0d fresh=%0d",
                                 $time, want.value, want.beat, want.ivl, want.fresh);
                        $display("%0t:          actual value=%0d event=%0d ivl=%0d fresh=%0d",
                                 $time, got.value, got.beat, got.ivl, got.fresh);
                        o_fails <= o_fails + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_beats.push_back(detect_beat(s_axis_tdata[11:0], s_axis_tdata[43:12]));
        end
    end

endmodule

// ----- sim/ppg_beat_detector_top_test.sv -----
module ppg_beat_detector_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pbd_pkg::*;

    localparam int CycleLimit = 1000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // adc_sample[11:0], time_us[43:12], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // filtered_value, beat_event, interval_ms, fresh
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    int pending, fails;
    int tx_idle_pct, rx_idle_pct;
    logic hold_req = 1'b0;
    int cycles = 0;

    // pulse waveform state
    logic [31:0] wave_us;
    int wave_n, wave_period, wave_amp, wave_dt;

    always #2 i_clk = ~i_clk;

    ppg_beat_detector_top u_dut (.*);

    ppg_beat_detector_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_fails(fails)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL ppg_beat_detector_top");
            $finish;
        end
    end

    // result side: random stall plus one long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req)
                hold_cnt = 400;
            if (hold_cnt > 0) begin
                m_axis_tready = 1'b0;
                hold_cnt--;
            end else begin
                m_axis_tready = (i_rst_n && $urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_sample(logic [11:0] adc, logic [31:0] t_us);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'd0, t_us, adc};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] refr, logic [31:0] mn, logic [31:0] mx,
                            logic [31:0] att, logic [31:0] dec, logic [31:0] ratio);
        write_reg(REG_REFRACTORY, refr);
        write_reg(REG_IVL_MIN, mn);
        write_reg(REG_IVL_MAX, mx);
        write_reg(REG_ATTACK, att);
        write_reg(REG_DECAY, dec);
        write_reg(REG_THR_RATIO, ratio);
    endtask

    // mostly a clean pulse shape with fresh shape every few beats, some noise
    task automatic run_pulses(int count);
        real r;
        int adc;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 12) begin
                send_sample(12'($urandom), $urandom);
            end else begin
                if (wave_n % wave_period == 0 && $urandom_range(3) == 0) begin
                    wave_period = $urandom_range(120, 25);
                    wave_amp = $urandom_range(2047, 100);
                    wave_dt = $urandom_range(14000, 3000);
                end
                r = $sin(6.2831853 * wave_n / wave_period);
                r = r + 0.5 * $sin(12.5663706 * wave_n / wave_period);
                adc = 2048 + int'(wave_amp * r * 0.7) + $urandom_range(20) - 10;
                adc = adc < 0 ? 0 : (adc > 4095 ? 4095 : adc);
                send_sample(12'(adc), wave_us);
                wave_us = wave_us + wave_dt + $urandom_range(500);
                wave_n++;
            end
        end
    endtask

    initial begin
        tx_idle_pct = 9;
        rx_idle_pct = 49;
        wave_us = 32'd0;
        wave_n = 0;
        wave_period = 60;
        wave_amp = 1500;
        wave_dt = 10000;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // extremes of sample and timestamp, peak near time zero
        send_sample(12'd0, 32'd0);
        send_sample(12'd4095, 32'hFFFF_FFFF);
        send_sample(12'd4095, 32'd0);
        send_sample(12'd0, 32'd1);
        send_sample(12'h555, 32'h5555_5555);
        send_sample(12'hAAA, 32'hAAAA_AAAA);
        send_sample(12'd0, 32'h8000_0000);
        send_sample(12'd4095, 32'h7FFF_FFFF);
        for (int i = 0; i < 14; i++)
            send_sample(i < 4 ? 12'd2048 + 12'(i * 400) : 12'd2048 - 12'((i - 4) * 150),
                        32'(i * 20000));
        wave_us = 32'd400000;
        run_pulses(110);
        drain();

        // wide-open intervals, no refractory, instant envelope, zero threshold
        set_regs(0, 0, 16'hFFFF, 16'hFFFF, 0, 0);
        write_reg(CfgIdxW'(6), 32'hFFFF_FFFF);
        write_reg(CfgIdxW'(7), 32'h0);
        run_pulses(110);
        drain();

        // min above max, maximal refractory, full ratio, timestamp wrap
        tx_idle_pct = 49;
        rx_idle_pct = 9;
        set_regs(32'hFFFF_FFFF, 1000, 500, 0, 16'hFFFF, 16'hFFFF);
        wave_us = 32'hFFFF_FFFF - 32'd3000000;
        run_pulses(100);
        drain();

        // typical settings with a long hold-off on the result side
        set_regs(200000, 100, 1500, 30000, 2000, 20000);
        wave_us = 32'hFFFF_FFFF - 32'd1500000;
        hold_req = 1'b1;
        repeat (2) @(negedge i_clk);
        hold_req = 1'b0;
        run_pulses(150);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_regs(300000, 250, 2000, 26214, 1311, 9830);
        run_pulses(150);
        drain();

        if (fails == 0 && pending == 0) begin
            $display("PASS ppg_beat_detector_top");
        end else begin
            $display("FAIL ppg_beat_detector_top");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pbd_pkg.sv
rtl/pbd_ctrl.sv
rtl/pbd_datapath.sv
rtl/ppg_beat_detector_top.sv
sim/ppg_beat_detector_checker.sv
sim/ppg_beat_detector_top_test.sv
